### hdl/chassis_wheel_mix_drive_macros.svh
// assertion helpers shared by the checker files
`ifndef CHASSIS_WHEEL_MIX_DRIVE_MACROS_SVH
`define CHASSIS_WHEEL_MIX_DRIVE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CWMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CWMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cwmd_pkg.sv
`timescale 1ns / 1ps

package cwmd_pkg;

  localparam int VEL_W  = 16;  // input velocity components
  localparam int SMAX_W = 15;  // speed_max
  localparam int PWM_W  = 16;  // duty full scale and duties
  localparam int SUM_W  = 18;  // exact three-term wheel sums
  localparam int MAG_W  = 17;  // wheel magnitudes and divisors
  localparam int NUM_W  = 32;  // dividend width
  localparam int QUO_W  = 16;  // quotient bits, one divider stage each
  localparam int NWHEEL = 4;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int MODE_W = 2;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_MOVE  = 2'd0;
  localparam logic [OP_W-1:0] OP_COAST = 2'd1;
  localparam logic [OP_W-1:0] OP_BRAKE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_COAST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REV   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BRAKE = 2'd3;

  localparam logic [1:0] REG_SPEED_MAX = 2'd0;
  localparam logic [1:0] REG_SPEED_MIN = 2'd1;
  localparam logic [1:0] REG_DUTY_FULL = 2'd2;

  typedef struct packed {
    logic [SMAX_W-1:0]       speed_max;
    logic signed [VEL_W-1:0] speed_min;
    logic [PWM_W-1:0]        duty_full;
  } cwmd_cfg_t;

  typedef struct packed {
    logic [NWHEEL-1:0][MODE_W-1:0] mode;
    logic [NWHEEL-1:0][PWM_W-1:0]  duty;
  } cwmd_res_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } cwmd_div_t;

  // one restoring division step for quotient bit b
  function automatic cwmd_div_t div_step(cwmd_div_t acc, logic [MAG_W-1:0] dvs,
                                         int unsigned b);
    logic [NUM_W-1:0] sub;
    cwmd_div_t        res;
    sub = {{(NUM_W-MAG_W){1'b0}}, dvs} << b;
    res = acc;
    if (acc.rem >= sub) begin
      res.rem = acc.rem - sub;
      res.quo = acc.quo | (QUO_W'(1) << b);
    end
    return res;
  endfunction

endpackage

### hdl/chassis_wheel_mix_drive.sv
// mecanum drive mixer: each transaction on the in_ side is one motion command
// (operation in in_tuser, vel_x/vel_y/turn_rate in in_tdata) and yields exactly
// one transaction on the out_ side with a direction mode and a pwm compare value
// per wheel. a move clamps the three components to [speed_min, speed_max], mixes
// them into four exact wheel sums, scales all wheels by speed_max/maxabs when the
// largest magnitude is above speed_max (quotient truncated toward zero), clamps
// again and converts each wheel to a mode and duty |w|*duty_full/speed_max capped
// at duty_full. coast gives all zeros, brake gives mode 3 with full duty. one
// command is accepted every cycle while the skid entry is empty; the pipeline
// depth is set by the two 16-stage restoring dividers (one quotient bit per
// stage) plus the mixing, multiply and select stages. a one-entry skid behind the
// output register keeps in_tready a flop output. the user writes registers over
// the apb port only while no command is in flight; the block does not enforce it.
`timescale 1ns / 1ps

module chassis_wheel_mix_drive import cwmd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // command stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,   // vel_x[15:0], vel_y[31:16], turn_rate[47:32]
  input  logic [OP_W-1:0]   in_tuser,   // operation[1:0]
  // wheel stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [71:0]       out_tdata,  // wheel1..4_mode[7:0], wheel1..4_duty[71:8]
  // register port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [SMAX_W-1:0]       speed_max_r;
  logic signed [VEL_W-1:0] speed_min_r;
  logic [PWM_W-1:0]        duty_full_r;
  logic                    cfg_wr;
  cwmd_cfg_t               cfg;
  cwmd_res_t               res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register index is the word address, low address bits ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_max_r <= SMAX_W'(1000);
      speed_min_r <= -VEL_W'(1000);
      duty_full_r <= PWM_W'(1000);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_SPEED_MAX: speed_max_r <= cfg_pwdata[SMAX_W-1:0];
        REG_SPEED_MIN: speed_min_r <= cfg_pwdata[VEL_W-1:0];
        REG_DUTY_FULL: duty_full_r <= cfg_pwdata[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SPEED_MAX: cfg_prdata = {{(CFG_DW-SMAX_W){1'b0}}, speed_max_r};
      REG_SPEED_MIN: cfg_prdata = {{(CFG_DW-VEL_W){speed_min_r[VEL_W-1]}}, speed_min_r};
      REG_DUTY_FULL: cfg_prdata = {{(CFG_DW-PWM_W){1'b0}}, duty_full_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg.speed_max = speed_max_r;
  assign cfg.speed_min = speed_min_r;
  assign cfg.duty_full = duty_full_r;

  // clamp, mix, normalize, duty divide, output skid
  cwmd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_vx     (in_tdata[15:0]),
    .in_vy     (in_tdata[31:16]),
    .in_turn   (in_tdata[47:32]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // modes in the low byte, wheel 1 lowest; duties above
  assign out_tdata = {res.duty, res.mode};

endmodule

### hdl/cwmd_core.sv
`timescale 1ns / 1ps

module cwmd_core import cwmd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cwmd_cfg_t               cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_op,
  input  logic signed [VEL_W-1:0] in_vx,
  input  logic signed [VEL_W-1:0] in_vy,
  input  logic signed [VEL_W-1:0] in_turn,
  output logic                    out_valid,
  input  logic                    out_ready,
  output cwmd_res_t               out_res
);

  localparam int NSTG = 6 + QUO_W + 2 + QUO_W;

  function automatic logic signed [SUM_W-1:0] sx(logic signed [VEL_W-1:0] v);
    return {{(SUM_W-VEL_W){v[VEL_W-1]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] clamp_speed(logic signed [SUM_W-1:0] v,
                                                          logic [SMAX_W-1:0] smax,
                                                          logic signed [VEL_W-1:0] smin);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-SMAX_W){1'b0}}, smax};
    lo = sx(smin);
    if (v > hi) return hi;
    else if (v < lo) return lo;
    else return v;
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] a;
    a = v[SUM_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  logic [NSTG-1:0] vld_r;
  logic            en;
  logic            push;
  logic            take;

  // stage 1: raw command
  logic [OP_W-1:0]         op1_r;
  logic signed [VEL_W-1:0] x1_r, y1_r, t1_r;
  // stage 2: clamped components
  logic [OP_W-1:0]         op2_r;
  logic signed [VEL_W-1:0] x2_r, y2_r, t2_r;
  // stage 3: wheel sums
  logic [OP_W-1:0]                     op3_r;
  logic [NWHEEL-1:0][SUM_W-1:0]        sum3_r;
  // stage 4: magnitudes
  logic [OP_W-1:0]                     op4_r;
  logic [NWHEEL-1:0][SUM_W-1:0]        sum4_r;
  logic [NWHEEL-1:0][MAG_W-1:0]        mag4_r;
  // stage 5: largest magnitude
  logic [OP_W-1:0]                     op5_r;
  logic [NWHEEL-1:0][SUM_W-1:0]        sum5_r;
  logic [NWHEEL-1:0][MAG_W-1:0]        mag5_r;
  logic [MAG_W-1:0]                    max5_r;
  // stage 6: products for normalization
  logic [OP_W-1:0]                     op6_r;
  logic [NWHEEL-1:0][SUM_W-1:0]        sum6_r;
  logic                                norm6_r;
  logic [MAG_W-1:0]                    max6_r;
  logic [NWHEEL-1:0][NUM_W-1:0]        prod6_r;
  // normalization divider
  logic [OP_W-1:0]                     d1_op_r   [QUO_W];
  logic [NWHEEL-1:0][SUM_W-1:0]        d1_sum_r  [QUO_W];
  logic                                d1_norm_r [QUO_W];
  logic [MAG_W-1:0]                    d1_dvs_r  [QUO_W];
  cwmd_div_t                           d1_acc_r  [QUO_W][NWHEEL];
  // stage after divider: modes and magnitudes
  logic [OP_W-1:0]                     op7_r;
  logic [NWHEEL-1:0][MODE_W-1:0]       mode7_r;
  logic [NWHEEL-1:0][MAG_W-1:0]        mag7_r;
  // duty products
  logic [OP_W-1:0]                     op8_r;
  logic [NWHEEL-1:0][MODE_W-1:0]       mode8_r;
  logic [NWHEEL-1:0]                   zero8_r;
  logic [NWHEEL-1:0]                   sat8_r;
  logic [NWHEEL-1:0][SMAX_W+PWM_W-1:0] prod8_r;
  // duty divider
  logic [OP_W-1:0]                     d2_op_r   [QUO_W];
  logic [NWHEEL-1:0][MODE_W-1:0]       d2_mode_r [QUO_W];
  logic [NWHEEL-1:0]                   d2_zero_r [QUO_W];
  logic [NWHEEL-1:0]                   d2_sat_r  [QUO_W];
  cwmd_div_t                           d2_acc_r  [QUO_W][NWHEEL];

  logic [NWHEEL-1:0][SUM_W-1:0] sum3_nxt;
  logic [MAG_W-1:0]             max01, max23;
  logic [NWHEEL-1:0][SUM_W-1:0] val7;
  logic [NWHEEL-1:0][SUM_W-1:0] clp7;
  logic [MAG_W-1:0]             dvs2;
  cwmd_res_t                    fin;
  cwmd_res_t                    out_r;
  cwmd_res_t                    skid_r;
  logic                         out_vld_r;
  logic                         skid_full_r;
  logic [QUO_W-1:0]             q2;
  logic [PWM_W-1:0]             duty_calc;

  assign en       = !skid_full_r;
  assign in_ready = en;
  assign push     = en && vld_r[NSTG-1];
  assign take     = out_vld_r && out_ready;
  assign dvs2     = {{(MAG_W-SMAX_W){1'b0}}, cfg.speed_max};

  always_comb begin
    sum3_nxt[0] = sx(x2_r) + sx(y2_r) - sx(t2_r);
    sum3_nxt[1] = -sx(x2_r) + sx(y2_r) - sx(t2_r);
    sum3_nxt[2] = sx(x2_r) - sx(y2_r) - sx(t2_r);
    sum3_nxt[3] = -sx(x2_r) - sx(y2_r) - sx(t2_r);
    max01 = (mag4_r[0] > mag4_r[1]) ? mag4_r[0] : mag4_r[1];
    max23 = (mag4_r[2] > mag4_r[3]) ? mag4_r[2] : mag4_r[3];
  end

  // pick the normalized or the plain sum, then clamp once more
  always_comb begin
    for (int k = 0; k < NWHEEL; k++) begin
      if (d1_norm_r[QUO_W-1]) begin
        if (d1_sum_r[QUO_W-1][k][SUM_W-1])
          val7[k] = -{{(SUM_W-QUO_W){1'b0}}, d1_acc_r[QUO_W-1][k].quo};
        else
          val7[k] = {{(SUM_W-QUO_W){1'b0}}, d1_acc_r[QUO_W-1][k].quo};
      end else begin
        val7[k] = d1_sum_r[QUO_W-1][k];
      end
      clp7[k] = clamp_speed(val7[k], cfg.speed_max, cfg.speed_min);
    end
  end

  // final duty and command override
  always_comb begin
    fin = '0;
    for (int k = 0; k < NWHEEL; k++) begin
      q2 = d2_acc_r[QUO_W-1][k].quo;
      if (d2_zero_r[QUO_W-1][k])
        duty_calc = '0;
      else if (cfg.speed_max == '0 || d2_sat_r[QUO_W-1][k])
        duty_calc = cfg.duty_full;
      else if (q2 > cfg.duty_full)
        duty_calc = cfg.duty_full;
      else
        duty_calc = q2;
      case (d2_op_r[QUO_W-1])
        OP_MOVE: begin
          fin.mode[k] = d2_mode_r[QUO_W-1][k];
          fin.duty[k] = duty_calc;
        end
        OP_BRAKE: begin
          fin.mode[k] = MODE_BRAKE;
          fin.duty[k] = cfg.duty_full;
        end
        default: begin
          fin.mode[k] = MODE_COAST;
          fin.duty[k] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_op;
      x1_r  <= in_vx;
      y1_r  <= in_vy;
      t1_r  <= in_turn;

      op2_r <= op1_r;
      x2_r  <= VEL_W'(clamp_speed(sx(x1_r), cfg.speed_max, cfg.speed_min));
      y2_r  <= VEL_W'(clamp_speed(sx(y1_r), cfg.speed_max, cfg.speed_min));
      t2_r  <= VEL_W'(clamp_speed(sx(t1_r), cfg.speed_max, cfg.speed_min));

      op3_r  <= op2_r;
      sum3_r <= sum3_nxt;

      op4_r  <= op3_r;
      sum4_r <= sum3_r;
      for (int k = 0; k < NWHEEL; k++) mag4_r[k] <= mag_of(sum3_r[k]);

      op5_r  <= op4_r;
      sum5_r <= sum4_r;
      mag5_r <= mag4_r;
      max5_r <= (max01 > max23) ? max01 : max23;

      op6_r   <= op5_r;
      sum6_r  <= sum5_r;
      max6_r  <= max5_r;
      norm6_r <= max5_r > {{(MAG_W-SMAX_W){1'b0}}, cfg.speed_max};
      for (int k = 0; k < NWHEEL; k++)
        prod6_r[k] <= NUM_W'(mag5_r[k]) * NUM_W'(cfg.speed_max);

      // normalization divider, most significant quotient bit first
      d1_op_r[0]   <= op6_r;
      d1_sum_r[0]  <= sum6_r;
      d1_norm_r[0] <= norm6_r;
      d1_dvs_r[0]  <= max6_r;
      for (int k = 0; k < NWHEEL; k++)
        d1_acc_r[0][k] <= div_step('{rem: prod6_r[k], quo: '0}, max6_r, QUO_W-1);
      for (int j = 1; j < QUO_W; j++) begin
        d1_op_r[j]   <= d1_op_r[j-1];
        d1_sum_r[j]  <= d1_sum_r[j-1];
        d1_norm_r[j] <= d1_norm_r[j-1];
        d1_dvs_r[j]  <= d1_dvs_r[j-1];
        for (int k = 0; k < NWHEEL; k++)
          d1_acc_r[j][k] <= div_step(d1_acc_r[j-1][k], d1_dvs_r[j-1], QUO_W-1-j);
      end

      op7_r <= d1_op_r[QUO_W-1];
      for (int k = 0; k < NWHEEL; k++) begin
        if (clp7[k][SUM_W-1]) begin
          mode7_r[k] <= MODE_REV;
          mag7_r[k]  <= mag_of(clp7[k]);
        end else if (clp7[k] != '0) begin
          mode7_r[k] <= MODE_FWD;
          mag7_r[k]  <= clp7[k][MAG_W-1:0];
        end else begin
          mode7_r[k] <= MODE_COAST;
          mag7_r[k]  <= '0;
        end
      end

      // a wheel above full scale saturates, its quotient is not used
      op8_r   <= op7_r;
      mode8_r <= mode7_r;
      for (int k = 0; k < NWHEEL; k++) begin
        zero8_r[k] <= (mag7_r[k] == '0);
        sat8_r[k]  <= mag7_r[k] > {{(MAG_W-SMAX_W){1'b0}}, cfg.speed_max};
        prod8_r[k] <= (SMAX_W+PWM_W)'(mag7_r[k][SMAX_W-1:0]) *
                      (SMAX_W+PWM_W)'(cfg.duty_full);
      end

      // duty divider by speed_max
      d2_op_r[0]   <= op8_r;
      d2_mode_r[0] <= mode8_r;
      d2_zero_r[0] <= zero8_r;
      d2_sat_r[0]  <= sat8_r;
      for (int k = 0; k < NWHEEL; k++)
        d2_acc_r[0][k] <= div_step('{rem: {{(NUM_W-SMAX_W-PWM_W){1'b0}}, prod8_r[k]},
                                     quo: '0}, dvs2, QUO_W-1);
      for (int j = 1; j < QUO_W; j++) begin
        d2_op_r[j]   <= d2_op_r[j-1];
        d2_mode_r[j] <= d2_mode_r[j-1];
        d2_zero_r[j] <= d2_zero_r[j-1];
        d2_sat_r[j]  <= d2_sat_r[j-1];
        for (int k = 0; k < NWHEEL; k++)
          d2_acc_r[j][k] <= div_step(d2_acc_r[j-1][k], dvs2, QUO_W-1-j);
      end
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_vld_r || take) begin
      out_vld_r   <= skid_full_r || push;
      skid_full_r <= 1'b0;
    end else if (push) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || take) begin
      out_r <= skid_full_r ? skid_r : fin;
    end else if (push) begin
      skid_r <= fin;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

endmodule

### hdl/cwmd_checker.sv
`timescale 1ns / 1ps
`include "chassis_wheel_mix_drive_macros.svh"

module cwmd_checker import cwmd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [71:0]       out_tdata,
  input logic              cfg_pready
);

  `CWMD_ASSERT_IMP(a_pready_high, 1'b1, cfg_pready, "apb pready dropped")

  // a coasting wheel never carries duty
  `CWMD_ASSERT_IMP(a_coast_zero_duty, out_tvalid,
    (out_tdata[1:0] != MODE_COAST || out_tdata[23:8] == '0) &&
    (out_tdata[3:2] != MODE_COAST || out_tdata[39:24] == '0) &&
    (out_tdata[5:4] != MODE_COAST || out_tdata[55:40] == '0) &&
    (out_tdata[7:6] != MODE_COAST || out_tdata[71:56] == '0),
    "coast wheel with nonzero duty")

  // brake only comes from a brake command, which hits all wheels
  `CWMD_ASSERT_IMP(a_brake_all, out_tvalid && out_tdata[1:0] == MODE_BRAKE,
    out_tdata[3:2] == MODE_BRAKE && out_tdata[5:4] == MODE_BRAKE &&
    out_tdata[7:6] == MODE_BRAKE,
    "brake on some wheels only")

  `CWMD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind chassis_wheel_mix_drive cwmd_checker u_cwmd_checker (.*);

### verif/chassis_wheel_mix_drive_test.sv
`timescale 1ns / 1ps

// mecanum mixer bench: commands go in on the in_ stream, a local model of the
// mixer predicts the four wheel modes and duties for every accepted command,
// and a monitor on the out_ stream checks each result transaction against the
// oldest prediction, wheel by wheel and field by field
module chassis_wheel_mix_drive_test;
  import cwmd_pkg::*;

  // operation code with no meaning of its own, the block treats it as coast
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef logic [71:0] wheel_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [47:0]       in_tdata = '0;   // vel_x[15:0], vel_y[31:16], turn_rate[47:32]
  logic [OP_W-1:0]   in_tuser = '0;   // operation[1:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [71:0]       out_tdata;       // wheel1..4_mode[7:0], wheel1..4_duty[71:8]
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // shadow copy of the registers, reset values of the block
  longint lim_max = 1000;
  longint lim_min = -1000;
  longint pwm_full = 1000;

  // wheel results predicted for accepted commands, oldest first
  wheel_word_t expected_wheels[$];
  wheel_word_t want_word;

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // long receiver hold-off, counted down in its own process
  logic hold_req = 1'b0;
  int   hold_left = 0;

  chassis_wheel_mix_drive dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // clamp in the block's order: upper bound first, then lower bound
  function automatic longint clamp_speed(input longint v);
    if (v > lim_max) return lim_max;
    if (v < lim_min) return lim_min;
    return v;
  endfunction

  // inverse kinematics, normalization and duty conversion for one command
  function automatic wheel_word_t mix_wheels(input logic [OP_W-1:0] op,
                                             input logic signed [15:0] vx_raw,
                                             input logic signed [15:0] vy_raw,
                                             input logic signed [15:0] tr_raw);
    longint      vx, vy, tr, maxabs, v, mag, duty;
    longint      sum [4];
    wheel_word_t word;
    int          i;
    word = '0;
    maxabs = 0;
    if (op == OP_BRAKE) begin
      for (i = 0; i < 4; i++) begin
        word[2*i +: 2]     = MODE_BRAKE;
        word[8+16*i +: 16] = pwm_full[15:0];
      end
      return word;
    end
    // coast and the unused code leave everything at zero
    if (op != OP_MOVE) return word;
    vx = clamp_speed(longint'(vx_raw));
    vy = clamp_speed(longint'(vy_raw));
    tr = clamp_speed(longint'(tr_raw));
    sum[0] = vx + vy - tr;
    sum[1] = -vx + vy - tr;
    sum[2] = vx - vy - tr;
    sum[3] = -vx - vy - tr;
    for (i = 0; i < 4; i++) begin
      mag = (sum[i] < 0) ? -sum[i] : sum[i];
      if (mag > maxabs) maxabs = mag;
    end
    // scale every wheel down when one is over full scale, truncating to zero
    if (maxabs > lim_max)
      for (i = 0; i < 4; i++) sum[i] = (sum[i] * lim_max) / maxabs;
    for (i = 0; i < 4; i++) begin
      v = clamp_speed(sum[i]);
      mag = (v < 0) ? -v : v;
      if (mag == 0) duty = 0;
      else if (lim_max == 0) duty = pwm_full;
      else duty = (mag * pwm_full) / lim_max;
      if (duty > pwm_full) duty = pwm_full;
      word[2*i +: 2]     = (v > 0) ? MODE_FWD : ((v < 0) ? MODE_REV : MODE_COAST);
      word[8+16*i +: 16] = duty[15:0];
    end
    return word;
  endfunction

  // result monitor: every out_ transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_wheels.size() == 0) begin
        report_mismatch($sformatf("result 0x%h with no command pending", out_tdata));
      end else begin
        want_word = expected_wheels.pop_front();
        for (int w = 0; w < 4; w++) begin
          if (out_tdata[2*w +: 2] !== want_word[2*w +: 2])
            report_mismatch($sformatf("wheel%0d mode got %0d want %0d", w + 1,
                            out_tdata[2*w +: 2], want_word[2*w +: 2]));
          if (out_tdata[8+16*w +: 16] !== want_word[8+16*w +: 16])
            report_mismatch($sformatf("wheel%0d duty got %0d want %0d", w + 1,
                            out_tdata[8+16*w +: 16], want_word[8+16*w +: 16]));
        end
      end
    end
  end

  // receiver: random stalls, or held off completely while hold_left runs
  always @(posedge clk) begin
    out_tready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (hold_req) hold_left <= 300;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // one command transaction; in_tvalid stays up when the next one follows at once
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [15:0] vx,
                          input logic [15:0] vy, input logic [15:0] tr);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {tr, vy, vx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_wheels.push_back(mix_wheels(op, vx, vy, tr));
  endtask

  // velocity values spread over the full field, the configured range and the edges
  function automatic logic [15:0] pick_speed();
    int span;
    span = int'(lim_max) + 20;
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 2 * span)) - span);
      2: begin
        case ($urandom_range(4))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return lim_max[15:0];
          default: return lim_min[15:0];
        endcase
      end
      default: return 16'(int'($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  task automatic send_random_cmds(input int count);
    logic [OP_W-1:0] op;
    int              pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 74) op = OP_MOVE;
      else if (pick < 85) op = OP_COAST;
      else if (pick < 95) op = OP_BRAKE;
      else op = OP_UNUSED;
      send_cmd(op, pick_speed(), pick_speed(), pick_speed());
    end
  endtask

  // let every prediction come back so registers can be touched safely
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_wheels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SPEED_MAX: lim_max  = longint'(value[14:0]);
      REG_SPEED_MIN: lim_min  = longint'($signed(value[15:0]));
      REG_DUTY_FULL: pwm_full = longint'(value[15:0]);
      default: ;
    endcase
  endtask

  task automatic set_limits(input int smax, input int smin, input int period);
    drain_results();
    write_reg(REG_SPEED_MAX, 32'(smax));
    write_reg(REG_SPEED_MIN, 32'(smin));
    write_reg(REG_DUTY_FULL, 32'(period));
  endtask

  // reset limits: zero, extremes, single components, normalization, bypass codes
  task automatic test_directed_cmds();
    send_cmd(OP_MOVE, 16'd0, 16'd0, 16'd0);
    send_cmd(OP_MOVE, 16'h7fff, 16'h7fff, 16'h7fff);
    send_cmd(OP_MOVE, 16'h8000, 16'h8000, 16'h8000);
    send_cmd(OP_MOVE, 16'h7fff, 16'h8000, 16'h0000);
    send_cmd(OP_MOVE, 16'd500, 16'd0, 16'd0);
    send_cmd(OP_MOVE, 16'd0, 16'd500, 16'd0);
    send_cmd(OP_MOVE, 16'd0, 16'd0, 16'd500);
    send_cmd(OP_MOVE, 16'd0, 16'd0, -16'sd500);
    send_cmd(OP_MOVE, 16'd300, 16'd200, 16'd100);
    send_cmd(OP_MOVE, 16'd1000, 16'd1000, 16'd0);
    send_cmd(OP_MOVE, -16'sd1000, 16'd1000, -16'sd1000);
    send_cmd(OP_MOVE, -16'sd1001, 16'd1001, 16'd0);
    send_cmd(OP_MOVE, 16'd1, 16'd0, 16'd0);
    send_cmd(OP_MOVE, 16'd333, -16'sd777, 16'd123);
    send_cmd(OP_MOVE, 16'd5, 16'd5, 16'd10);
    send_cmd(OP_COAST, 16'd1234, -16'sd5, 16'h7fff);
    send_cmd(OP_BRAKE, 16'h8000, 16'hffff, 16'd42);
    send_cmd(OP_UNUSED, 16'h5555, 16'haaaa, 16'h7fff);
    send_cmd(OP_BRAKE, 16'd0, 16'd0, 16'd0);
    send_cmd(OP_MOVE, 16'hffff, 16'hffff, 16'hffff);
  endtask

  // register extremes, zero full scale and an empty clamp range
  task automatic test_register_settings();
    set_limits(32767, -32768, 65535);
    send_random_cmds(30);
    set_limits(1, -1, 1);
    send_random_cmds(30);
    set_limits(1, -32768, 65535);     // wheels clamped far below, duty saturates
    send_random_cmds(30);
    set_limits(0, -1000, 1000);       // zero full scale
    send_random_cmds(25);
    set_limits(50, 200, 777);         // lower bound above upper bound
    send_random_cmds(25);
    set_limits($urandom_range(1, 32767), -int'($urandom_range(1, 32768)),
               $urandom_range(1, 65535));
    send_random_cmds(30);
  endtask

  // sender and receiver idling in several mixes
  task automatic test_idle_patterns();
    set_limits(1000, -1000, 1000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_cmds(40);
    send_idle_pct = 52;
    send_random_cmds(40);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    send_random_cmds(40);
    set_limits($urandom_range(1, 32767), -int'($urandom_range(1, 32768)),
               $urandom_range(1, 65535));
    send_idle_pct = 12;
    recv_stall_pct = 12;
    send_random_cmds(40);
  endtask

  // receiver holds off long enough for the pipeline to fill and stall in_tready
  task automatic test_backpressure();
    drain_results();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_random_cmds(60);
    recv_stall_pct = 30;
    send_random_cmds(20);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cmds();
    test_register_settings();
    test_idle_patterns();
    test_backpressure();
    drain_results();
    repeat (50) @(posedge clk);
    if (expected_wheels.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_wheels.size()));
    if (mismatch_count == 0) begin
      $display("chassis_wheel_mix_drive verification clean");
    end else begin
      $display("chassis_wheel_mix_drive verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("chassis_wheel_mix_drive verification failed");
    $finish;
  end

endmodule
